// File: src/lbt_pkg.sv
// lbt_pkg: shared types, constants and helpers for the led blink timer
// beat structs, controller/datapath command and status, state encoding
// no dependencies
`timescale 1ns / 1ps

package lbt_pkg;

   localparam int unsigned MaxDurationSec = 60;
   localparam int unsigned MsPerSec       = 1000;
   localparam int unsigned TickReset      = 5;

   localparam int unsigned TickWidth   = 8;
   localparam int unsigned MsWidth     = 16;
   localparam int unsigned NextWidth   = MsWidth + 1;
   localparam int unsigned DivisorWidth = 9;
   localparam int unsigned DivSteps    = MsWidth;
   localparam int unsigned DivCntWidth = $clog2(DivSteps);
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   // register index taken from paddr[2]
   localparam logic CsrRegMsPerTick = 1'b0;

   localparam logic CmdTick  = 1'b0;
   localparam logic CmdStart = 1'b1;

   localparam logic [1:0] ColorRed   = 2'd0;
   localparam logic [1:0] ColorGreen = 2'd1;
   localparam logic [1:0] ColorBlue  = 2'd2;
   localparam logic [1:0] ColorNone  = 2'd3;

   typedef struct packed {
      logic       command;
      logic [1:0] color;
      logic [7:0] duration_sec;
      logic [7:0] blink_count;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic busy_res;
      logic red_on;
      logic green_on;
      logic blue_on;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic start;
      logic tick;
      logic div_step;
      logic load_interval;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic start_ok;
      logic is_tick;
      logic div_last;
   } status_type;

   typedef enum logic [3:0] {
      StIdle = 4'b0001,
      StDiv  = 4'b0010,
      StLoad = 4'b0100,
      StEmit = 4'b1000
   } state_type;

   function automatic logic [2:0] color_bit(input logic [1:0] c);
      logic [2:0] b;
      case (c)
         ColorRed:   b = 3'b001;
         ColorGreen: b = 3'b010;
         ColorBlue:  b = 3'b100;
         default:    b = 3'b000;
      endcase
      return b;
   endfunction

endpackage

// File: src/lbt_ctrl.sv
// lbt_ctrl: sequencing state machine for the led blink timer
// issues datapath commands, depends on lbt_pkg
`timescale 1ns / 1ps

module lbt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                rsp_free,
   input  lbt_pkg::status_type status,
   output lbt_pkg::cmd_type    cmd
);
   import lbt_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != StIdle);
   assign accept    = req_valid && (state_ff == StIdle);

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.accept        = accept;
      cmd.start         = accept && status.start_ok;
      cmd.tick          = accept && status.is_tick;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = status.start_ok ? StDiv : StEmit;
            end
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = StLoad;
            end
         end
         StLoad: begin
            cmd.load_interval = 1'b1;
            state_in          = StEmit;
         end
         StEmit: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/lbt_datapath.sv
// lbt_datapath: blink state, millisecond counters and serial divider
// driven by lbt_ctrl commands, depends on lbt_pkg
`timescale 1ns / 1ps

module lbt_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lbt_pkg::req_type                    req_data,
   input  logic [lbt_pkg::TickWidth-1:0]       ms_per_tick,
   input  lbt_pkg::cmd_type                    cmd,
   output lbt_pkg::status_type                 status,
   output lbt_pkg::rsp_type                    rsp_next
);
   import lbt_pkg::*;

   logic                    running_ff, running_in;
   logic [1:0]              active_color_ff, active_color_in;
   logic [MsWidth-1:0]      elapsed_ff, elapsed_in;
   logic [MsWidth-1:0]      total_ff, total_in;
   logic [MsWidth-1:0]      interval_ff, interval_in;
   logic [NextWidth-1:0]    next_ff, next_in;
   logic [2:0]              led_ff, led_in;
   logic                    acc_ff, acc_in;
   logic [DivisorWidth-1:0] divisor_ff, divisor_in;
   logic [DivisorWidth-1:0] rem_ff, rem_in;
   logic [MsWidth-1:0]      quot_ff, quot_in;
   logic [DivCntWidth-1:0]  cnt_ff, cnt_in;

   logic [17:0]             total_ms_full;
   logic [DivisorWidth:0]   trial;
   logic                    trial_ge;
   logic [MsWidth-1:0]      elapsed_base;
   logic [2:0]              active_bit;
   logic                    dur_ok;

   assign dur_ok = (req_data.duration_sec != 8'd0) &&
                   ({24'd0, req_data.duration_sec} <= MaxDurationSec);
   assign status.start_ok = (req_data.command == CmdStart) && !running_ff && dur_ok;
   assign status.is_tick  = (req_data.command == CmdTick);
   assign status.div_last = (cnt_ff == DivCntWidth'(DivSteps - 1));

   assign total_ms_full = 18'(req_data.duration_sec) * 18'(MsPerSec);
   assign active_bit    = color_bit(active_color_ff);

   // one quotient bit per step
   assign trial    = {rem_ff, quot_ff[MsWidth-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});

   always_comb begin
      running_in      = running_ff;
      active_color_in = active_color_ff;
      elapsed_in      = elapsed_ff;
      total_in        = total_ff;
      interval_in     = interval_ff;
      next_in         = next_ff;
      led_in          = led_ff;
      acc_in          = acc_ff;
      divisor_in      = divisor_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      cnt_in          = cnt_ff;
      elapsed_base    = elapsed_ff;

      if (cmd.accept) begin
         acc_in = cmd.start;
      end

      if (cmd.start) begin
         running_in      = 1'b1;
         active_color_in = req_data.color;
         led_in          = led_ff | color_bit(req_data.color);
         elapsed_in      = '0;
         total_in        = total_ms_full[MsWidth-1:0];
         quot_in         = total_ms_full[MsWidth-1:0];
         rem_in          = '0;
         cnt_in          = '0;
         if (req_data.blink_count > 8'd1) begin
            divisor_in = {req_data.blink_count, 1'b0} - DivisorWidth'(1);
         end else begin
            divisor_in = DivisorWidth'(1);
         end
      end

      if (cmd.tick && running_ff) begin
         if ({1'b0, elapsed_ff} >= next_ff) begin
            led_in  = led_ff ^ active_bit;
            next_in = next_ff + {1'b0, interval_ff};
         end
         if (elapsed_ff > total_ff) begin
            led_in       = led_in & ~active_bit;
            running_in   = 1'b0;
            elapsed_base = '0;
         end
         elapsed_in = elapsed_base + {{(MsWidth-TickWidth){1'b0}}, ms_per_tick};
      end

      if (cmd.div_step) begin
         if (trial_ge) begin
            rem_in = DivisorWidth'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[DivisorWidth-1:0];
         end
         quot_in = {quot_ff[MsWidth-2:0], trial_ge};
         cnt_in  = cnt_ff + DivCntWidth'(1);
      end

      if (cmd.load_interval) begin
         interval_in = quot_ff;
         next_in     = {1'b0, quot_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff      <= 1'b0;
         active_color_ff <= ColorGreen;
         elapsed_ff      <= '0;
         total_ff        <= '0;
         interval_ff     <= '0;
         next_ff         <= '0;
         led_ff          <= '0;
         acc_ff          <= 1'b0;
      end else begin
         running_ff      <= running_in;
         active_color_ff <= active_color_in;
         elapsed_ff      <= elapsed_in;
         total_ff        <= total_in;
         interval_ff     <= interval_in;
         next_ff         <= next_in;
         led_ff          <= led_in;
         acc_ff          <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      cnt_ff     <= cnt_in;
   end

   assign rsp_next.accepted = acc_ff;
   assign rsp_next.busy_res = running_ff;
   assign rsp_next.red_on   = led_ff[0];
   assign rsp_next.green_on = led_ff[1];
   assign rsp_next.blue_on  = led_ff[2];

   // only the active led can be lit
   a_led_active_only: assert property (@(posedge clock) disable iff (reset)
      (led_ff & ~active_bit) == 3'b000)
      else $error("led lit that is not the active color");

   a_dark_when_idle: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (led_ff == 3'b000))
      else $error("led lit while no sequence runs");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> running_ff && acc_ff)
      else $error("accepted start did not begin a sequence");

   a_interval_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_interval |=> (interval_ff != '0) && (next_ff == {1'b0, interval_ff}))
      else $error("divider produced a zero toggle interval");

endmodule

// File: src/led_blink_timer.sv
// led_blink_timer: top level of the three-color led blink sequencer
// holds the csr register and the result beat register, uses lbt_pkg, lbt_ctrl, lbt_datapath
//
//   channel  direction  handshake           payload
//   req_     in         req_valid/req_stall req_data (lbt_pkg::req_type)
//   rsp_     out        rsp_valid/rsp_stall rsp_data (lbt_pkg::rsp_type)
//   csr_     in         apb psel/penable    ms_per_tick at byte address 0
//
// tick beats and refused starts: result registered in StEmit when rsp_free is high
// accepted start: 16-step serial divider, then StLoad, then result registered in StEmit
// one beat at a time; req_stall stays high until the result is registered
// a held rsp_stall delays only the hand-off into the result register
// synchronous reset clears sequence state and sets ms_per_tick to 5
`timescale 1ns / 1ps

module led_blink_timer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lbt_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lbt_pkg::rsp_type                   rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lbt_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [lbt_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [lbt_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import lbt_pkg::*;

   logic [TickWidth-1:0] ms_per_tick_ff, ms_per_tick_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   rsp_type              rsp_next;
   cmd_type              cmd;
   status_type           status;
   logic                 rsp_free;
   logic                 csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      ms_per_tick_in = ms_per_tick_ff;
      if (csr_write && (csr_paddr[2] == CsrRegMsPerTick)) begin
         ms_per_tick_in = csr_pwdata[TickWidth-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CsrRegMsPerTick: csr_prdata = {{(CsrDataWidth-TickWidth){1'b0}}, ms_per_tick_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_per_tick_ff <= TickWidth'(TickReset);
         rsp_valid_ff   <= 1'b0;
      end else begin
         ms_per_tick_ff <= ms_per_tick_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_free  (rsp_free),
      .status    (status),
      .cmd       (cmd)
   );

   lbt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .ms_per_tick (ms_per_tick_ff),
      .cmd         (cmd),
      .status      (status),
      .rsp_next    (rsp_next)
   );

endmodule
